@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge outside reset.
`define CHK_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define CHK_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/uvs_pkg.sv @@
`default_nettype none
package uvs_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_RINGS    = 2'd1;
    localparam logic [1:0] REG_SEGMENTS = 2'd2;

    localparam logic signed [33:0] INV_GAIN = 34'sd652032874;
    localparam logic signed [15:0] ONE_Q14  = 16'sd16384;

    typedef struct packed {
        logic [8:0]  ring;
        logic [8:0]  seg;
        logic [8:0]  ring_lim;
        logic [8:0]  seg_lim;
        logic [16:0] count;
        logic        quad;
        logic        last;
    } t_job;

    // Arctangent of 2^-i in binary phase units (2^32 per turn).
    function automatic logic signed [32:0] atan_step(input logic [4:0] idx);
        logic signed [32:0] v;
        case (idx)
            5'd0:    v = 33'sd536870912;
            5'd1:    v = 33'sd316933406;
            5'd2:    v = 33'sd167458907;
            5'd3:    v = 33'sd85004756;
            5'd4:    v = 33'sd42667331;
            5'd5:    v = 33'sd21354465;
            5'd6:    v = 33'sd10679838;
            5'd7:    v = 33'sd5340245;
            5'd8:    v = 33'sd2670163;
            5'd9:    v = 33'sd1335087;
            5'd10:   v = 33'sd667544;
            5'd11:   v = 33'sd333772;
            5'd12:   v = 33'sd166886;
            5'd13:   v = 33'sd83443;
            5'd14:   v = 33'sd41722;
            5'd15:   v = 33'sd20861;
            5'd16:   v = 33'sd10430;
            5'd17:   v = 33'sd5215;
            5'd18:   v = 33'sd2608;
            5'd19:   v = 33'sd1304;
            5'd20:   v = 33'sd652;
            5'd21:   v = 33'sd326;
            5'd22:   v = 33'sd163;
            5'd23:   v = 33'sd81;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] clamp_q14(input logic signed [33:0] v);
        logic signed [15:0] r;
        if (v > 34'sd16384) begin
            r = ONE_Q14;
        end else if (v < -34'sd16384) begin
            r = -ONE_Q14;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/uvs_front.sv @@
`default_nettype none
`include "assert_macros.svh"
module uvs_front
    import uvs_pkg::*;
#(
    parameter int MAX_RINGS    = 256,
    parameter int MAX_SEGMENTS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_restart,
    input  wire logic [15:0] i_radius,
    input  wire logic [8:0]  i_ring_count,
    input  wire logic [8:0]  i_segment_count,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_job             o_job
);

    logic [8:0]  r_ring, n_ring;
    logic [8:0]  r_seg, n_seg;
    logic [16:0] r_count, n_count;
    logic        r_done, n_done;

    logic [8:0] w_nr, w_ns;
    logic       w_acc, w_zero, w_beyond, w_last;

    assign w_nr = (int'(i_ring_count) > MAX_RINGS) ? 9'(MAX_RINGS) : i_ring_count;
    assign w_ns = (int'(i_segment_count) > MAX_SEGMENTS) ? 9'(MAX_SEGMENTS) : i_segment_count;

    assign o_ready  = !i_q_full;
    assign w_acc    = i_valid && !i_q_full;
    assign w_zero   = (i_radius == 16'd0) || (i_ring_count == 9'd0) ||
                      (i_segment_count == 9'd0);
    assign w_beyond = (r_ring > w_nr) || (r_seg > w_ns);
    assign w_last   = (r_ring == w_nr) && (r_seg == w_ns);

    assign o_push = w_acc && !i_restart && !r_done && !w_zero && !w_beyond;

    always_comb begin
        o_job.ring     = r_ring;
        o_job.seg      = r_seg;
        o_job.ring_lim = w_nr;
        o_job.seg_lim  = w_ns;
        o_job.count    = r_count;
        o_job.quad     = (r_ring != w_nr);
        o_job.last     = w_last;
    end

    always_comb begin
        n_ring  = r_ring;
        n_seg   = r_seg;
        n_count = r_count;
        n_done  = r_done;
        if (w_acc) begin
            priority if (i_restart) begin
                n_ring  = '0;
                n_seg   = '0;
                n_count = '0;
                n_done  = 1'b0;
            end else if (r_done || w_zero) begin
                n_done = r_done;
            end else if (w_beyond || w_last) begin
                // The walk ends; positions go back to the start.
                n_ring  = '0;
                n_seg   = '0;
                n_count = '0;
                n_done  = 1'b1;
            end else begin
                if (r_seg == w_ns) begin
                    n_seg  = '0;
                    n_ring = r_ring + 9'd1;
                end else begin
                    n_seg = r_seg + 9'd1;
                end
                n_count = r_count + 17'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring  <= '0;
            r_seg   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_ring  <= n_ring;
            r_seg   <= n_seg;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    `CHK_NEXT(a_last_ends_walk, o_push && o_job.last, r_done && r_ring == 9'd0, "walk not ended after last vertex")

endmodule
`default_nettype wire

@@ sv/uvs_queue.sv @@
`default_nettype none
`include "assert_macros.svh"
module uvs_queue
    import uvs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `CHK_ALWAYS(a_count_bound, r_count <= CW'(QUEUE_DEPTH), "queue count overflow")
    `CHK_IMPLY(a_pop_nonempty, i_pop, r_count != '0, "pop from empty queue")

endmodule
`default_nettype wire

@@ sv/uvs_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module uvs_back
    import uvs_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_empty,
    output logic             o_pop,
    input  wire t_job        i_job,
    input  wire logic [15:0] i_radius,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [16:0]      o_pos_x,
    output logic [16:0]      o_pos_y,
    output logic [16:0]      o_pos_z,
    output logic [15:0]      o_norm_x,
    output logic [15:0]      o_norm_y,
    output logic [15:0]      o_norm_z,
    output logic [16:0]      o_tex_u,
    output logic [16:0]      o_tex_v,
    output logic [16:0]      o_vertex_index,
    output logic [16:0]      o_upper_index,
    output logic             o_has_quad,
    output logic             o_last_vertex
);

    localparam int CSW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic signed [32:0] Q_QTR  = 33'sh040000000;
    localparam logic signed [32:0] Q_HALF = 33'sh080000000;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_DIV  = 9'b000000010,
        ST_COR  = 9'b000000100,
        ST_MNX  = 9'b000001000,
        ST_MNZ  = 9'b000010000,
        ST_MPX  = 9'b000100000,
        ST_MPY  = 9'b001000000,
        ST_MPZ  = 9'b010000000,
        ST_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    t_job   r_job;
    logic   r_pass;          // 0 while working on the ring angle, 1 on the segment angle
    logic   r_ov;

    logic [8:0]  r_rem;
    logic        r_qhi;
    logic [31:0] r_qlo;
    logic [4:0]  r_dcnt;

    logic signed [33:0] r_cx, r_cy;
    logic signed [32:0] r_cz;
    logic               r_neg;
    logic [CSW-1:0]     r_cstep;

    logic signed [15:0] r_rs, r_rc, r_ss, r_sc, r_nx, r_nz;
    logic [16:0]        r_px, r_py, r_pz, r_tex_u, r_tex_v;

    logic [16:0] r_o_px, r_o_py, r_o_pz, r_o_tu, r_o_tv, r_o_vi, r_o_ui;
    logic [15:0] r_o_nx, r_o_ny, r_o_nz;
    logic        r_o_quad, r_o_last;

    // Divider start values.
    logic [8:0] w_ds_num, w_ds_den, w_ds_rem;
    logic       w_ds_ge;
    // Divider step.
    logic [8:0]  w_den, w_rem_n;
    logic [9:0]  w_trial;
    logic        w_dbit, w_div_end;
    logic [31:0] w_qlo_n, w_phase;
    logic [16:0] w_q_top;
    // CORDIC.
    logic signed [32:0] w_z0, w_z0f;
    logic               w_fold;
    logic signed [33:0] w_xs, w_ys, w_cx_n, w_cy_n, w_fx, w_fy;
    logic signed [32:0] w_at, w_cz_n;
    logic               w_cor_end;
    logic signed [15:0] w_sin, w_cos;
    // Shared multiplier.
    logic signed [16:0] w_ma, w_mb, w_rad;
    logic signed [33:0] w_prod, w_round;
    logic               w_out_load;

    assign o_pop      = (r_state == ST_IDLE) && !i_empty;
    assign w_out_load = (r_state == ST_OUT) && (!r_ov || i_ready);

    // The first pass starts from the queue head, the second from the held job.
    always_comb begin
        if (r_state == ST_IDLE) begin
            w_ds_num = i_job.ring;
            w_ds_den = i_job.ring_lim;
        end else begin
            w_ds_num = r_job.seg;
            w_ds_den = r_job.seg_lim;
        end
        w_ds_ge  = (w_ds_num >= w_ds_den);
        w_ds_rem = w_ds_ge ? (w_ds_num - w_ds_den) : w_ds_num;
    end

    assign w_den     = r_pass ? r_job.seg_lim : r_job.ring_lim;
    assign w_trial   = {r_rem, 1'b0};
    assign w_dbit    = (w_trial >= {1'b0, w_den});
    assign w_rem_n   = w_dbit ? 9'(w_trial - {1'b0, w_den}) : w_trial[8:0];
    assign w_qlo_n   = {r_qlo[30:0], w_dbit};
    assign w_q_top   = {r_qhi, w_qlo_n[31:16]};
    assign w_phase   = r_pass ? w_qlo_n : {r_qhi, w_qlo_n[31:1]};
    assign w_div_end = (r_dcnt == 5'd31);

    // Fold the phase into a quarter turn either side of zero.
    always_comb begin
        w_z0 = {w_phase[31], w_phase};
        if (w_z0 > Q_QTR) begin
            w_z0f  = w_z0 - Q_HALF;
            w_fold = 1'b1;
        end else if (w_z0 < -Q_QTR) begin
            w_z0f  = w_z0 + Q_HALF;
            w_fold = 1'b1;
        end else begin
            w_z0f  = w_z0;
            w_fold = 1'b0;
        end
    end

    always_comb begin
        w_xs = r_cx >>> r_cstep;
        w_ys = r_cy >>> r_cstep;
        w_at = atan_step(5'(r_cstep));
        if (!r_cz[32]) begin
            w_cx_n = r_cx - w_ys;
            w_cy_n = r_cy + w_xs;
            w_cz_n = r_cz - w_at;
        end else begin
            w_cx_n = r_cx + w_ys;
            w_cy_n = r_cy - w_xs;
            w_cz_n = r_cz + w_at;
        end
        w_fx = (w_cx_n + 34'sd32768) >>> 16;
        w_fy = (w_cy_n + 34'sd32768) >>> 16;
        if (r_neg) begin
            w_fx = -w_fx;
            w_fy = -w_fy;
        end
        w_cos = clamp_q14(w_fx);
        w_sin = clamp_q14(w_fy);
    end

    assign w_cor_end = (r_cstep == CSW'(CORDIC_STEPS - 1));

    assign w_rad = $signed({1'b0, i_radius});

    always_comb begin
        unique case (r_state)
            ST_MNX: begin
                w_ma = {r_rs[15], r_rs};
                w_mb = {r_ss[15], r_ss};
            end
            ST_MNZ: begin
                w_ma = {r_rs[15], r_rs};
                w_mb = {r_sc[15], r_sc};
            end
            ST_MPX: begin
                w_ma = {r_nx[15], r_nx};
                w_mb = w_rad;
            end
            ST_MPY: begin
                w_ma = {r_rc[15], r_rc};
                w_mb = w_rad;
            end
            ST_MPZ: begin
                w_ma = {r_nz[15], r_nz};
                w_mb = w_rad;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod  = w_ma * w_mb;
        w_round = (w_prod + 34'sd8192) >>> 14;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (!i_empty) n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_end) begin
                    n_state = (!r_pass && r_job.seg != 9'd0) ? ST_DIV : ST_COR;
                end
            end
            ST_COR: begin
                if (w_cor_end) begin
                    n_state = r_pass ? ST_MNX : ST_DIV;
                end
            end
            ST_MNX: n_state = ST_MNZ;
            ST_MNZ: n_state = ST_MPX;
            ST_MPX: n_state = ST_MPY;
            ST_MPY: n_state = ST_MPZ;
            ST_MPZ: n_state = ST_OUT;
            ST_OUT: if (w_out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    r_job  <= i_job;
                    r_pass <= 1'b0;
                    r_rem  <= w_ds_rem;
                    r_qhi  <= w_ds_ge;
                    r_qlo  <= '0;
                    r_dcnt <= '0;
                end
            end
            ST_DIV: begin
                r_rem  <= w_rem_n;
                r_qlo  <= w_qlo_n;
                r_dcnt <= r_dcnt + 5'd1;
                if (w_div_end) begin
                    if (!r_pass) begin
                        r_tex_v <= 17'(17'd65536 - w_q_top);
                    end else begin
                        r_tex_u <= w_q_top;
                    end
                    if (!r_pass && r_job.seg != 9'd0) begin
                        // Ring angle still held from segment zero of this ring.
                        r_pass <= 1'b1;
                        r_rem  <= w_ds_rem;
                        r_qhi  <= w_ds_ge;
                        r_qlo  <= '0;
                    end else begin
                        r_cx    <= INV_GAIN;
                        r_cy    <= '0;
                        r_cz    <= w_z0f;
                        r_neg   <= w_fold;
                        r_cstep <= '0;
                    end
                end
            end
            ST_COR: begin
                r_cx    <= w_cx_n;
                r_cy    <= w_cy_n;
                r_cz    <= w_cz_n;
                r_cstep <= r_cstep + CSW'(1);
                if (w_cor_end) begin
                    if (!r_pass) begin
                        r_rs   <= w_sin;
                        r_rc   <= w_cos;
                        r_pass <= 1'b1;
                        r_rem  <= w_ds_rem;
                        r_qhi  <= w_ds_ge;
                        r_qlo  <= '0;
                        r_dcnt <= '0;
                    end else begin
                        r_ss <= w_sin;
                        r_sc <= w_cos;
                    end
                end
            end
            ST_MNX: r_nx <= clamp_q14(w_round);
            ST_MNZ: r_nz <= clamp_q14(w_round);
            ST_MPX: r_px <= w_round[16:0];
            ST_MPY: r_py <= w_round[16:0];
            ST_MPZ: r_pz <= w_round[16:0];
            ST_OUT: begin
                if (w_out_load) begin
                    r_o_px   <= r_px;
                    r_o_py   <= r_py;
                    r_o_pz   <= r_pz;
                    r_o_nx   <= r_nx;
                    r_o_ny   <= r_rc;
                    r_o_nz   <= r_nz;
                    r_o_tu   <= r_tex_u;
                    r_o_tv   <= r_tex_v;
                    r_o_vi   <= r_job.count;
                    r_o_ui   <= r_job.quad ?
                                17'(r_job.count + 17'(r_job.seg_lim) + 17'd1) : '0;
                    r_o_quad <= r_job.quad;
                    r_o_last <= r_job.last;
                end
            end
            default: r_dcnt <= r_dcnt;
        endcase
    end

    assign o_valid        = r_ov;
    assign o_pos_x        = r_o_px;
    assign o_pos_y        = r_o_py;
    assign o_pos_z        = r_o_pz;
    assign o_norm_x       = r_o_nx;
    assign o_norm_y       = r_o_ny;
    assign o_norm_z       = r_o_nz;
    assign o_tex_u        = r_o_tu;
    assign o_tex_v        = r_o_tv;
    assign o_vertex_index = r_o_vi;
    assign o_upper_index  = r_o_ui;
    assign o_has_quad     = r_o_quad;
    assign o_last_vertex  = r_o_last;

    `CHK_NEXT(a_result_posted, w_out_load, r_ov && r_state == ST_IDLE, "result not posted")

endmodule
`default_nettype wire

@@ sv/uv_sphere_vertex_generator.sv @@
// A vertex step passes the 32-step serial divider (run twice per vertex) and the CORDIC
// unit of CORDIC_STEPS iterations (run once, twice on segment zero of a ring) before
// it reaches the result register. The back end works on one vertex at a time while the
// queue holds further steps; restart and empty steps produce no vertex.
// Reset (synchronous, active low): radius 256, 16 rings, 16 segments, walk at ring 0.
`default_nettype none
module uv_sphere_vertex_generator
    import uvs_pkg::*;
#(
    parameter int MAX_RINGS    = 256,
    parameter int MAX_SEGMENTS = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_restart,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [16:0]      o_pos_x,
    output logic [16:0]      o_pos_y,
    output logic [16:0]      o_pos_z,
    output logic [15:0]      o_norm_x,
    output logic [15:0]      o_norm_y,
    output logic [15:0]      o_norm_z,
    output logic [16:0]      o_tex_u,
    output logic [16:0]      o_tex_v,
    output logic [16:0]      o_vertex_index,
    output logic [16:0]      o_upper_index,
    output logic             o_has_quad,
    output logic             o_last_vertex,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_radius;
    logic [8:0]  r_ring_count, r_segment_count;

    logic q_full, q_empty, q_push, q_pop;
    t_job q_in, q_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius        <= 16'd256;
            r_ring_count    <= 9'd16;
            r_segment_count <= 9'd16;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_RADIUS) r_radius <= i_cfg_data;
            if (i_cfg_index == REG_RINGS) r_ring_count <= i_cfg_data[8:0];
            if (i_cfg_index == REG_SEGMENTS) r_segment_count <= i_cfg_data[8:0];
        end
    end

    uvs_front #(
        .MAX_RINGS    (MAX_RINGS),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_restart       (i_restart),
        .i_radius        (r_radius),
        .i_ring_count    (r_ring_count),
        .i_segment_count (r_segment_count),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_job           (q_in)
    );

    uvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_out)
    );

    uvs_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .i_job          (q_out),
        .i_radius       (r_radius),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_pos_z        (o_pos_z),
        .o_norm_x       (o_norm_x),
        .o_norm_y       (o_norm_y),
        .o_norm_z       (o_norm_z),
        .o_tex_u        (o_tex_u),
        .o_tex_v        (o_tex_v),
        .o_vertex_index (o_vertex_index),
        .o_upper_index  (o_upper_index),
        .o_has_quad     (o_has_quad),
        .o_last_vertex  (o_last_vertex)
    );

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none
module tb_top;
    import uvs_pkg::*;

    typedef struct packed {
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [16:0] vertex_index;
        logic [16:0] upper_index;
        logic        has_quad;
        logic        last_vertex;
    } t_vertex;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_index;
        logic [15:0] reg_data;
        bit          restart;
        bit          typed;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [16:0] vertex_index;
        logic [16:0] upper_index;
        bit          has_quad;
        bit          last_vertex;
    } t_row;

    localparam int RING_LIMIT = 256;
    localparam int SEG_LIMIT  = 256;
    localparam int ROTATIONS  = 16;
    localparam int DRAIN_CYCLES = 120;
    localparam int ITEM_TARGET = 1900;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_restart;
    logic        o_valid;
    logic        i_ready;
    logic [16:0] o_pos_x, o_pos_y, o_pos_z;
    logic [15:0] o_norm_x, o_norm_y, o_norm_z;
    logic [16:0] o_tex_u, o_tex_v, o_vertex_index, o_upper_index;
    logic        o_has_quad, o_last_vertex;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    uv_sphere_vertex_generator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_restart(i_restart),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_norm_x(o_norm_x), .o_norm_y(o_norm_y), .o_norm_z(o_norm_z),
        .o_tex_u(o_tex_u), .o_tex_v(o_tex_v),
        .o_vertex_index(o_vertex_index), .o_upper_index(o_upper_index),
        .o_has_quad(o_has_quad), .o_last_vertex(o_last_vertex),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow of the generator's registers and walk state.
    longint  radius_q88;
    longint  rings;
    longint  segments;
    longint  cur_ring;
    longint  cur_seg;
    longint  vert_count;
    longint  held_sin;
    longint  held_cos;
    bit      walk_done;

    t_vertex pending_vertices[$];
    t_row    stim_rows[$];
    int      fail_count;
    int      items_sent;
    bit      no_idle;
    bit      hold_request;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint clamp_unit(input longint v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    function automatic void cordic_sincos(input longint phase, output longint sn,
                                          output longint cs);
        longint atan_tab[16] = '{536870912, 316933406, 167458907, 85004756,
                                 42667331, 21354465, 10679838, 5340245,
                                 2670163, 1335087, 667544, 333772,
                                 166886, 83443, 41722, 20861};
        longint z, x, y, t;
        bit     flip;
        z = phase;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z >= (64'sd1 << 31)) z = z - (64'sd1 << 32);
        // Fold into a quarter turn either side of zero and negate afterward.
        if (z > (64'sd1 << 30)) begin
            z = z - (64'sd1 << 31);
            flip = 1'b1;
        end else if (z < -(64'sd1 << 30)) begin
            z = z + (64'sd1 << 31);
            flip = 1'b1;
        end
        for (int i = 0; i < ROTATIONS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_tab[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_tab[i];
            end
            x = t;
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = clamp_unit(x);
        sn = clamp_unit(y);
    endfunction

    function automatic void clear_walk();
        cur_ring = 0;
        cur_seg = 0;
        vert_count = 0;
        held_sin = 0;
        held_cos = 16384;
    endfunction

    function automatic bit next_vertex(input bit restart, output t_vertex vx);
        longint nr, ns, seg_sin, seg_cos, nx, ny, nz, px, py, pz;
        longint tu, tv, up;
        bit     quad, last;
        vx = '0;
        if (restart) begin
            clear_walk();
            walk_done = 1'b0;
            return 1'b0;
        end
        if (walk_done || radius_q88 == 0 || rings == 0 || segments == 0) return 1'b0;
        nr = (rings > RING_LIMIT) ? RING_LIMIT : rings;
        ns = (segments > SEG_LIMIT) ? SEG_LIMIT : segments;
        // A config change can leave the position past the new counts.
        if (cur_ring > nr || cur_seg > ns) begin
            clear_walk();
            walk_done = 1'b1;
            return 1'b0;
        end
        if (cur_seg == 0) cordic_sincos((cur_ring << 31) / nr, held_sin, held_cos);
        cordic_sincos(((cur_seg << 32) / ns) & 64'hFFFF_FFFF, seg_sin, seg_cos);
        nx = clamp_unit((held_sin * seg_sin + 8192) >>> 14);
        ny = held_cos;
        nz = clamp_unit((held_sin * seg_cos + 8192) >>> 14);
        px = (nx * radius_q88 + 8192) >>> 14;
        py = (ny * radius_q88 + 8192) >>> 14;
        pz = (nz * radius_q88 + 8192) >>> 14;
        quad = (cur_ring != nr);
        last = (cur_ring == nr) && (cur_seg == ns);
        tu = (cur_seg << 16) / ns;
        tv = 65536 - ((cur_ring << 16) / nr);
        up = quad ? (vert_count + ns + 1) : 0;
        vx.pos_x = px[16:0];
        vx.pos_y = py[16:0];
        vx.pos_z = pz[16:0];
        vx.norm_x = nx[15:0];
        vx.norm_y = ny[15:0];
        vx.norm_z = nz[15:0];
        vx.tex_u = tu[16:0];
        vx.tex_v = tv[16:0];
        vx.vertex_index = vert_count[16:0];
        vx.upper_index = up[16:0];
        vx.has_quad = quad;
        vx.last_vertex = last;
        if (last) begin
            clear_walk();
            walk_done = 1'b1;
        end else begin
            if (cur_seg == ns) begin
                cur_seg = 0;
                cur_ring = cur_ring + 1;
            end else begin
                cur_seg = cur_seg + 1;
            end
            vert_count = (vert_count + 1) & 17'h1FFFF;
        end
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
        if (want !== got) begin
            $error("%s expected 0x%05h actual 0x%05h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_vertex want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_vertices.size() == 0) begin
                $error("vertex transfer with nothing expected, index 0x%05h", o_vertex_index);
                fail_count++;
            end else begin
                want = pending_vertices.pop_front();
                check_field("pos_x", want.pos_x, o_pos_x);
                check_field("pos_y", want.pos_y, o_pos_y);
                check_field("pos_z", want.pos_z, o_pos_z);
                check_field("norm_x", {1'b0, want.norm_x}, {1'b0, o_norm_x});
                check_field("norm_y", {1'b0, want.norm_y}, {1'b0, o_norm_y});
                check_field("norm_z", {1'b0, want.norm_z}, {1'b0, o_norm_z});
                check_field("tex_u", want.tex_u, o_tex_u);
                check_field("tex_v", want.tex_v, o_tex_v);
                check_field("vertex_index", want.vertex_index, o_vertex_index);
                check_field("upper_index", want.upper_index, o_upper_index);
                check_field("has_quad", {16'd0, want.has_quad}, {16'd0, o_has_quad});
                check_field("last_vertex", {16'd0, want.last_vertex},
                            {16'd0, o_last_vertex});
            end
        end
    end

    // Receiver: random stalls per vertex, plus one long hold-off on request.
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_request = 1'b0;
                stall = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 13);
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic wait_drained();
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_RADIUS:   radius_q88 = data;
            REG_RINGS:    rings = data & 16'h1FF;
            REG_SEGMENTS: segments = data & 16'h1FF;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one step; a typed row overlays the values known by inspection.
    task automatic send_step(input t_row row);
        int      gap;
        bit      produced;
        t_vertex vx;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_restart <= row.restart;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        produced = next_vertex(row.restart, vx);
        if (row.typed) begin
            vx.tex_u = row.tex_u;
            vx.tex_v = row.tex_v;
            vx.vertex_index = row.vertex_index;
            vx.upper_index = row.upper_index;
            vx.has_quad = row.has_quad;
            vx.last_vertex = row.last_vertex;
        end
        if (produced || row.typed) pending_vertices.push_back(vx);
    endtask

    function automatic void add_cfg(input logic [1:0] idx, input logic [15:0] data);
        t_row row;
        row = '{default: 0};
        row.is_cfg = 1'b1;
        row.reg_index = idx;
        row.reg_data = data;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_step(input bit restart);
        t_row row;
        row = '{default: 0};
        row.restart = restart;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_known(input logic [16:0] tu, input logic [16:0] tv,
                                      input logic [16:0] vi, input logic [16:0] ui,
                                      input bit quad, input bit last);
        t_row row;
        row = '{default: 0};
        row.typed = 1'b1;
        row.tex_u = tu;
        row.tex_v = tv;
        row.vertex_index = vi;
        row.upper_index = ui;
        row.has_quad = quad;
        row.last_vertex = last;
        stim_rows.push_back(row);
    endfunction

    initial begin
        t_row row;
        bit   prev_cfg;
        int   phase_len;
        int   pick;
        fail_count = 0;
        items_sent = 0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_restart = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_RADIUS;
        i_cfg_data = '0;
        radius_q88 = 256;
        rings = 16;
        segments = 16;
        clear_walk();
        walk_done = 1'b0;

        // Default sphere straight out of reset.
        add_step(1'b1);
        add_known(17'd0, 17'd65536, 17'd0, 17'd17, 1'b1, 1'b0);
        add_known(17'd4096, 17'd65536, 17'd1, 17'd18, 1'b1, 1'b0);
        // Shrinking mid-walk leaves the position outside the sphere.
        add_cfg(REG_RADIUS, 16'hFFFF);
        add_cfg(REG_RINGS, 16'd1);
        add_cfg(REG_SEGMENTS, 16'd1);
        add_step(1'b0);
        add_step(1'b1);
        add_known(17'd0, 17'd65536, 17'd0, 17'd2, 1'b1, 1'b0);
        add_known(17'd65536, 17'd65536, 17'd1, 17'd3, 1'b1, 1'b0);
        add_known(17'd0, 17'd0, 17'd2, 17'd0, 1'b0, 1'b0);
        add_known(17'd65536, 17'd0, 17'd3, 17'd0, 1'b0, 1'b1);
        add_step(1'b0);
        add_step(1'b1);
        add_cfg(REG_RADIUS, 16'd0);
        add_step(1'b0);
        add_cfg(REG_RADIUS, 16'd1);
        add_cfg(REG_RINGS, 16'hFFFF);
        add_cfg(REG_SEGMENTS, 16'd0);
        add_step(1'b0);
        add_cfg(REG_SEGMENTS, 16'd300);
        add_step(1'b1);
        add_step(1'b0);
        add_step(1'b0);
        add_cfg(REG_RINGS, 16'd256);
        add_cfg(REG_SEGMENTS, 16'd256);
        add_step(1'b0);
        add_step(1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prev_cfg = 1'b1;
        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.is_cfg) begin
                if (!prev_cfg) begin
                    i_valid <= 1'b0;
                    wait_drained();
                end
                write_reg(row.reg_index, row.reg_data);
            end else begin
                send_step(row);
            end
            prev_cfg = row.is_cfg;
        end

        // Random phases; mostly small spheres so that walks can run to completion.
        hold_request = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            i_valid <= 1'b0;
            wait_drained();
            no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick == 0) write_reg(REG_RADIUS, 16'hFFFF);
            else if (pick == 1) write_reg(REG_RADIUS, 16'd0);
            else if (pick == 2) write_reg(REG_RADIUS, 16'd1);
            else write_reg(REG_RADIUS, 16'($urandom_range(0, 65535)));
            pick = $urandom_range(0, 19);
            if (pick == 0) write_reg(REG_RINGS, 16'($urandom_range(0, 65535)));
            else if (pick == 1) write_reg(REG_RINGS, 16'd256);
            else if (pick == 2) write_reg(REG_RINGS, 16'd0);
            else write_reg(REG_RINGS, 16'($urandom_range(1, 5)));
            pick = $urandom_range(0, 19);
            if (pick == 0) write_reg(REG_SEGMENTS, 16'($urandom_range(0, 65535)));
            else if (pick == 1) write_reg(REG_SEGMENTS, 16'd256);
            else if (pick == 2) write_reg(REG_SEGMENTS, 16'd0);
            else write_reg(REG_SEGMENTS, 16'($urandom_range(1, 5)));
            phase_len = $urandom_range(20, 80);
            row = '{default: 0};
            // Most phases restart cleanly; the rest continue the old walk.
            if ($urandom_range(0, 3) != 0) begin
                row.restart = 1'b1;
                send_step(row);
            end
            repeat (phase_len) begin
                row.restart = ($urandom_range(0, 24) == 0);
                send_step(row);
            end
        end
        i_valid <= 1'b0;
        wait_drained();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ uv_sphere_vertex_generator.f @@
+incdir+sv
sv/uvs_pkg.sv
sv/uvs_front.sv
sv/uvs_queue.sv
sv/uvs_back.sv
sv/uv_sphere_vertex_generator.sv
bench/tb_top.sv
